### sv/e2c_pkg.sv
package e2c_pkg;

  localparam int unsigned NUM_STAGES = 15;

  localparam int unsigned SEC_SHIFT      = 7;
  localparam int unsigned DAY_ODD        = 675;
  localparam int unsigned EPOCH_SHIFT    = 719468;
  localparam int unsigned WEEKDAY_SHIFT  = 4;
  localparam int unsigned DAYS_PER_WEEK  = 7;
  localparam int unsigned SEC_PER_HOUR   = 3600;
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned DAYS_PER_ERA   = 146097;
  localparam int unsigned DAYS_PER_4Y    = 1460;
  localparam int unsigned DAYS_PER_100Y  = 36524;
  localparam int unsigned DAYS_ERA_LAST  = 146096;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned YEARS_PER_CENT = 100;
  localparam int unsigned YEARS_PER_ERA  = 400;
  localparam int unsigned BASE_YEAR      = 1900;
  localparam int unsigned MP_JANUARY     = 10;
  localparam int unsigned MP_TO_MONTH    = 2;
  localparam int unsigned JAN_DOY_OFFSET = 305;
  localparam int unsigned MAR_DOY_OFFSET = 60;

  localparam int unsigned SOD_W  = 17;
  localparam int unsigned DOE_W  = 18;
  localparam int unsigned YOE_W  = 9;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned YEAR_W = 10;

  // first day of each month, counted from March 1
  localparam logic [DOY_W-1:0] MAR_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [NUM_STAGES:1] ld;
    logic [NUM_STAGES:1] valid;
  } ctl_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        dom;
    logic [DOY_W-1:0]  doy;
  } date_t;

  typedef struct packed {
    logic [2:0] wd;
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
  } tod_t;

endpackage

### sv/epoch_seconds_to_calendar.sv
// Converts a count of seconds since 1970-01-01 00:00:00 into a Gregorian
// calendar breakdown: year since 1900, month, day of month, day of year,
// weekday, hour, minute and second.
// Input channel in_*: one timestamp per transfer, low SECONDS_WIDTH bits of
// in_tdata; higher bits are ignored.
// Output channel out_*: one result per input, in input order.
// The pipeline has 15 register stages, built around the chain of constant
// dividers (seconds to days, days to 400-year era, era to year, year to
// century), each a registered multiply and a registered correction.
// Throughput: one transfer per cycle while out_tready stays high.
// When out_tready is low, the result holds in the output register and the
// pipeline keeps accepting input until every stage is full; in_tready then
// drops and nothing is lost or repeated.
// Reset clears all stage valid bits; no result is pending after reset.
module epoch_seconds_to_calendar #(
  parameter int unsigned SECONDS_WIDTH = 34,
  localparam int unsigned IN_TDATA_W = ((SECONDS_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // epoch_seconds
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata   // years_since_1900, month_index, day_of_month,
                                            // day_of_year, weekday, hour_of_day,
                                            // minute_of_hour, second_of_minute
);
  import e2c_pkg::*;

  localparam int unsigned XW1 = SECONDS_WIDTH - SEC_SHIFT;
  localparam int unsigned DW  = SECONDS_WIDTH - 16;
  localparam int unsigned ZW  = ((DW > 20) ? DW : 20) + 1;
  localparam int unsigned EW  = ZW - 17;
  localparam int unsigned WW  = DW + 1;

  ctl_t ctl;

  logic [SEC_SHIFT-1:0] t7_r [1:2];
  logic [DW-1:0]        days;
  logic [9:0]           rem675;
  logic [ZW-1:0]        z3_r;
  logic [WW-1:0]        w3_r;
  logic [SOD_W-1:0]     sec3_r;
  logic [EW-1:0]        era;
  logic [DOE_W-1:0]     doe;
  logic [2:0]           wday;
  logic [5:0]           hour_q;
  logic [11:0]          sec_of_hour;
  logic [6:0]           min_q;
  logic [5:0]           sec_q;
  logic [2:0]           wd6_r;
  logic [2:0]           wd7_r;
  logic [4:0]           hr6_r;
  logic [4:0]           hr7_r;
  tod_t                 tod_r [8:15];
  date_t                date;

  e2c_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid_i(in_tvalid), .out_ready_i(out_tready), .ctl_o(ctl)
  );

  e2c_cdiv #(.XW(XW1), .C(DAY_ODD)) u_div_day (
    .clk(clk), .en_a(ctl.ld[1]), .en_b(ctl.ld[2]),
    .x_i(in_tdata[SECONDS_WIDTH-1:SEC_SHIFT]), .q_o(days), .r_o(rem675)
  );

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      t7_r[1] <= in_tdata[SEC_SHIFT-1:0];
    end
    if (ctl.ld[2]) begin
      t7_r[2] <= t7_r[1];
    end
    if (ctl.ld[3]) begin
      z3_r   <= ZW'(days) + ZW'(EPOCH_SHIFT);
      w3_r   <= WW'(days) + WW'(WEEKDAY_SHIFT);
      sec3_r <= {rem675, t7_r[2]};
    end
  end

  e2c_cdiv #(.XW(ZW), .C(DAYS_PER_ERA)) u_div_era (
    .clk(clk), .en_a(ctl.ld[4]), .en_b(ctl.ld[5]), .x_i(z3_r), .q_o(era), .r_o(doe)
  );

  e2c_cdiv #(.XW(WW), .C(DAYS_PER_WEEK)) u_div_week (
    .clk(clk), .en_a(ctl.ld[4]), .en_b(ctl.ld[5]), .x_i(w3_r), .q_o(), .r_o(wday)
  );

  e2c_cdiv #(.XW(SOD_W), .C(SEC_PER_HOUR)) u_div_hour (
    .clk(clk), .en_a(ctl.ld[4]), .en_b(ctl.ld[5]), .x_i(sec3_r), .q_o(hour_q),
    .r_o(sec_of_hour)
  );

  e2c_cdiv #(.XW(12), .C(SEC_PER_MIN)) u_div_min (
    .clk(clk), .en_a(ctl.ld[6]), .en_b(ctl.ld[7]), .x_i(sec_of_hour), .q_o(min_q),
    .r_o(sec_q)
  );

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      wd6_r <= wday;
      hr6_r <= hour_q[4:0];
    end
    if (ctl.ld[7]) begin
      wd7_r <= wd6_r;
      hr7_r <= hr6_r;
    end
    if (ctl.ld[8]) begin
      tod_r[8] <= '{wd: wd7_r, hr: hr7_r, mi: min_q[5:0], se: sec_q};
    end
    for (int i = 9; i <= NUM_STAGES; i++) begin
      if (ctl.ld[i]) begin
        tod_r[i] <= tod_r[i-1];
      end
    end
  end

  e2c_date #(.EW(EW)) u_date (
    .clk(clk), .ctl_i(ctl), .era_i(era), .doe_i(doe), .date_o(date)
  );

  assign in_tready  = ctl.ld[1];
  assign out_tvalid = ctl.valid[NUM_STAGES];
  assign out_tdata  = {tod_r[15].se, tod_r[15].mi, tod_r[15].hr, tod_r[15].wd,
                       date.doy, date.dom, date.month, date.year};

  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (date.month < 4'd12) && (date.dom != 5'd0) && (date.doy != 9'd0) &&
                   (tod_r[15].wd < 3'd7) && (tod_r[15].hr < 5'd24) &&
                   (tod_r[15].mi < 6'd60) && (tod_r[15].se < 6'd60))
    else $error("calendar field out of range");

  a_january_doy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (date.month == 4'd0)) |-> (date.doy == {4'd0, date.dom}))
    else $error("day of year disagrees with January date");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

endmodule

### sv/e2c_ctl.sv
module e2c_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output e2c_pkg::ctl_t ctl_o
);
  import e2c_pkg::*;

  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] ld;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NUM_STAGES] = !v_r[NUM_STAGES] || out_ready_i;
    for (int i = NUM_STAGES - 1; i >= 1; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) begin
        v_r[1] <= in_valid_i;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign ctl_o.ld    = ld;
  assign ctl_o.valid = v_r;

endmodule

### sv/e2c_cdiv.sv
module e2c_cdiv #(
  parameter int unsigned XW = 18,
  parameter int unsigned C  = 365
) (
  input  logic                        clk,
  input  logic                        en_a,
  input  logic                        en_b,
  input  logic [XW-1:0]               x_i,
  output logic [XW-$clog2(C+1):0]     q_o,
  output logic [$clog2(C+1)-1:0]      r_o
);
  localparam int unsigned CW = $clog2(C + 1);
  localparam int unsigned QW = XW - CW + 1;
  localparam int unsigned PW = XW + QW;
  localparam logic [QW-1:0] RECIP = QW'((64'd1 << XW) / C);

  logic [PW-1:0] prod_r;
  logic [XW-1:0] x_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] r_r;
  logic [QW-1:0] q_est;
  logic [XW:0]   diff;
  logic [CW:0]   rem_est;
  logic [QW-1:0] q_nxt;
  logic [CW-1:0] r_nxt;

  // truncated reciprocal: estimate is exact or one short
  always_comb begin
    q_est   = prod_r[XW +: QW];
    diff    = {1'b0, x_r} - (XW+1)'((XW+1)'(q_est) * (XW+1)'(C));
    rem_est = diff[CW:0];
    if (rem_est >= (CW+1)'(C)) begin
      q_nxt = q_est + QW'(1);
      r_nxt = CW'(rem_est - (CW+1)'(C));
    end else begin
      q_nxt = q_est;
      r_nxt = rem_est[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= PW'(x_i) * PW'(RECIP);
      x_r    <= x_i;
    end
    if (en_b) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign q_o = q_r;
  assign r_o = r_r;

endmodule

### sv/e2c_date.sv
module e2c_date #(
  parameter int unsigned EW = 4
) (
  input  logic                          clk,
  input  e2c_pkg::ctl_t                 ctl_i,
  input  logic [EW-1:0]                 era_i,
  input  logic [e2c_pkg::DOE_W-1:0]     doe_i,
  output e2c_pkg::date_t                date_o
);
  import e2c_pkg::*;

  localparam int unsigned Q4Y_W   = DOE_W - $clog2(DAYS_PER_4Y + 1) + 1;
  localparam int unsigned Q100Y_W = DOE_W - $clog2(DAYS_PER_100Y + 1) + 1;
  localparam int unsigned QERA_W  = DOE_W - $clog2(DAYS_ERA_LAST + 1) + 1;
  localparam int unsigned QYR_W   = DOE_W - $clog2(DAYS_PER_YEAR + 1) + 1;
  localparam int unsigned QC_W    = YOE_W - $clog2(YEARS_PER_CENT + 1) + 1;
  localparam int unsigned RC_W    = $clog2(YEARS_PER_CENT + 1);
  localparam int unsigned E4_W    = EW + 9;

  logic [DOE_W-1:0]  doe_d_r [6:12];
  logic [EW-1:0]     era_d_r [6:12];
  logic [Q4Y_W-1:0]  q4y;
  logic [Q100Y_W-1:0] q100y;
  logic [QERA_W-1:0] qera;
  logic [DOE_W-1:0]  n8_r;
  logic [QYR_W-1:0]  qyr;
  logic [YOE_W-1:0]  yoe11_r;
  logic [YOE_W-1:0]  yoe12_r;
  logic [QC_W-1:0]   qcent;
  logic [RC_W-1:0]   rcent;
  logic [DOY_W-1:0]  doy13_r;
  logic              leap13_r;
  logic [YEAR_W-1:0] yb13_r;
  logic [DOY_W-1:0]  doy14_r;
  logic              leap14_r;
  logic [YEAR_W-1:0] yb14_r;
  logic [3:0]        mp14_r;
  date_t             date_r;

  logic [DOE_W-1:0]  doy_full;
  logic [E4_W-1:0]   era400;
  logic              leap_nxt;
  logic [YEAR_W-1:0] yb_nxt;
  logic [3:0]        mp_nxt;
  logic              jan;
  date_t             date_nxt;

  always_ff @(posedge clk) begin
    if (ctl_i.ld[6]) begin
      doe_d_r[6] <= doe_i;
      era_d_r[6] <= era_i;
    end
    for (int i = 7; i <= 12; i++) begin
      if (ctl_i.ld[i]) begin
        doe_d_r[i] <= doe_d_r[i-1];
        era_d_r[i] <= era_d_r[i-1];
      end
    end
  end

  e2c_cdiv #(.XW(DOE_W), .C(DAYS_PER_4Y)) u_div_4y (
    .clk(clk), .en_a(ctl_i.ld[6]), .en_b(ctl_i.ld[7]), .x_i(doe_i), .q_o(q4y), .r_o()
  );

  e2c_cdiv #(.XW(DOE_W), .C(DAYS_PER_100Y)) u_div_100y (
    .clk(clk), .en_a(ctl_i.ld[6]), .en_b(ctl_i.ld[7]), .x_i(doe_i), .q_o(q100y), .r_o()
  );

  e2c_cdiv #(.XW(DOE_W), .C(DAYS_ERA_LAST)) u_div_era (
    .clk(clk), .en_a(ctl_i.ld[6]), .en_b(ctl_i.ld[7]), .x_i(doe_i), .q_o(qera), .r_o()
  );

  // day count with leap days folded out, a multiple of 365 per year
  always_ff @(posedge clk) begin
    if (ctl_i.ld[8]) begin
      n8_r <= doe_d_r[7] - DOE_W'(q4y) + DOE_W'(q100y) - DOE_W'(qera);
    end
  end

  e2c_cdiv #(.XW(DOE_W), .C(DAYS_PER_YEAR)) u_div_year (
    .clk(clk), .en_a(ctl_i.ld[9]), .en_b(ctl_i.ld[10]), .x_i(n8_r), .q_o(qyr), .r_o()
  );

  e2c_cdiv #(.XW(YOE_W), .C(YEARS_PER_CENT)) u_div_cent (
    .clk(clk), .en_a(ctl_i.ld[11]), .en_b(ctl_i.ld[12]), .x_i(qyr[YOE_W-1:0]),
    .q_o(qcent), .r_o(rcent)
  );

  always_ff @(posedge clk) begin
    if (ctl_i.ld[11]) begin
      yoe11_r <= qyr[YOE_W-1:0];
    end
    if (ctl_i.ld[12]) begin
      yoe12_r <= yoe11_r;
    end
  end

  always_comb begin
    doy_full = doe_d_r[12]
             - DOE_W'(DOE_W'(yoe12_r) * DOE_W'(DAYS_PER_YEAR))
             - DOE_W'(yoe12_r >> 2)
             + DOE_W'(qcent);
    leap_nxt = (yoe12_r[1:0] == 2'd0) && ((rcent != '0) || (yoe12_r == '0));
    era400   = E4_W'(era_d_r[12]) * E4_W'(YEARS_PER_ERA);
    yb_nxt   = era400[YEAR_W-1:0] + YEAR_W'(yoe12_r) - YEAR_W'(BASE_YEAR);
  end

  always_ff @(posedge clk) begin
    if (ctl_i.ld[13]) begin
      doy13_r  <= doy_full[DOY_W-1:0];
      leap13_r <= leap_nxt;
      yb13_r   <= yb_nxt;
    end
  end

  always_comb begin
    mp_nxt = '0;
    for (int i = 1; i < 12; i++) begin
      mp_nxt = mp_nxt + {3'd0, (doy13_r >= MAR_START[i])};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.ld[14]) begin
      doy14_r  <= doy13_r;
      leap14_r <= leap13_r;
      yb14_r   <= yb13_r;
      mp14_r   <= mp_nxt;
    end
  end

  always_comb begin
    jan          = (mp14_r >= 4'(MP_JANUARY));
    date_nxt.dom = 5'(doy14_r - MAR_START[mp14_r] + DOY_W'(1));
    if (jan) begin
      date_nxt.month = mp14_r - 4'(MP_JANUARY);
      date_nxt.doy   = doy14_r - DOY_W'(JAN_DOY_OFFSET);
      date_nxt.year  = yb14_r + YEAR_W'(1);
    end else begin
      date_nxt.month = mp14_r + 4'(MP_TO_MONTH);
      date_nxt.doy   = doy14_r + DOY_W'(MAR_DOY_OFFSET) + DOY_W'(leap14_r);
      date_nxt.year  = yb14_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.ld[15]) begin
      date_r <= date_nxt;
    end
  end

  assign date_o = date_r;

endmodule

### tb/sv/epoch_seconds_to_calendar_tb.sv
module epoch_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2c_pkg::*;

  localparam int unsigned SECONDS_W   = 34;
  localparam int unsigned IN_W        = ((SECONDS_W + 7) / 8) * 8;
  localparam longint unsigned SEC_PER_DAY  = 86400;
  localparam longint unsigned SEC_PER_HR   = 3600;
  localparam longint unsigned SEC_PER_MN   = 60;
  localparam longint unsigned DAYS_IN_YEAR = 365;
  localparam longint unsigned EPOCH_YEAR   = 1970;
  localparam longint unsigned YEAR_BASE    = 1900;
  localparam longint unsigned MAX_SECONDS  = (64'd1 << SECONDS_W) - 1;
  localparam longint unsigned MAX_DAY      = MAX_SECONDS / SEC_PER_DAY;

  typedef struct packed {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [9:0] years_since_1900;
  } calendar_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [47:0]     out_tdata;

  calendar_t expected_dates[$];
  calendar_t want_date;
  calendar_t got_date;
  bit        failed;
  bit        idle_on;

  epoch_seconds_to_calendar i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit leap_year(input longint unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic longint unsigned leaps_upto(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic longint unsigned first_day_of(input longint unsigned y);
    return (y - EPOCH_YEAR) * DAYS_IN_YEAR + leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1);
  endfunction

  function automatic calendar_t predict_calendar(input logic [IN_W-1:0] raw);
    longint unsigned secs, whole_days, sod, year, hr, mn;
    longint          day_idx, mlen;
    int unsigned     month;
    calendar_t       c;
    int unsigned     month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    secs       = longint'(raw[SECONDS_W-1:0]);
    whole_days = secs / SEC_PER_DAY;
    sod        = secs - whole_days * SEC_PER_DAY;
    year       = EPOCH_YEAR + whole_days / DAYS_IN_YEAR;
    day_idx    = longint'(whole_days) - longint'(first_day_of(year));
    while (day_idx < 0) begin
      year    = year - 1;
      day_idx = day_idx + DAYS_IN_YEAR + (leap_year(year) ? 1 : 0);
    end
    c.years_since_1900 = 10'(year - YEAR_BASE);
    c.day_of_year      = 9'(day_idx + 1);
    for (month = 0; month < 11; month++) begin
      mlen = month_days[month] + ((month == 1 && leap_year(year)) ? 1 : 0);
      if (day_idx < mlen) break;
      day_idx = day_idx - mlen;
    end
    c.month_index      = 4'(month);
    c.day_of_month     = 5'(day_idx + 1);
    c.weekday          = 3'((whole_days + 4) % 7);
    hr                 = sod / SEC_PER_HR;
    sod                = sod - hr * SEC_PER_HR;
    mn                 = sod / SEC_PER_MN;
    c.hour_of_day      = 5'(hr);
    c.minute_of_hour   = 6'(mn);
    c.second_of_minute = 6'(sod - mn * SEC_PER_MN);
    return c;
  endfunction

  task automatic send_seconds(input logic [IN_W-1:0] stamp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
    expected_dates.push_back(predict_calendar(stamp));
  endtask

  task automatic wait_all_dates();
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] with_junk(input longint unsigned secs);
    logic [IN_W-1:0] v;
    v = IN_W'({$urandom, $urandom});
    v[SECONDS_W-1:0] = secs[SECONDS_W-1:0];
    return v;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_date = calendar_t'(out_tdata);
      if (expected_dates.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual %h",
                 $time, out_tdata);
        failed = 1'b1;
      end else begin
        want_date = expected_dates.pop_front();
        check_field("years_since_1900", want_date.years_since_1900,
                    got_date.years_since_1900);
        check_field("month_index", want_date.month_index, got_date.month_index);
        check_field("day_of_month", want_date.day_of_month, got_date.day_of_month);
        check_field("day_of_year", want_date.day_of_year, got_date.day_of_year);
        check_field("weekday", want_date.weekday, got_date.weekday);
        check_field("hour_of_day", want_date.hour_of_day, got_date.hour_of_day);
        check_field("minute_of_hour", want_date.minute_of_hour,
                    got_date.minute_of_hour);
        check_field("second_of_minute", want_date.second_of_minute,
                    got_date.second_of_minute);
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic test_directed();
    logic [IN_W-1:0] stamps[] = '{
      40'd0, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
      40'd94608000,    // last day of a leap year, first estimate one year high
      40'd94694399, 40'd94694400,
      40'd951782400,   // leap day of a 400-year leap year
      40'd951868800,
      40'd978220800,   // day 366
      40'd2147483647, 40'd2147483648,
      40'd4107456000,  // century year without leap day
      40'd4107542400,
      40'd4294967295, 40'd4294967296,
      40'd13574563200, // leap day far out
      40'd17179869183,
      40'hFF_FFFF_FFFF,
      40'hFC_0000_0000,
      40'hA8_0000_0001
    };
    idle_on = 1'b1;
    foreach (stamps[i]) send_seconds(stamps[i]);
  endtask

  task automatic test_year_edges(input int unsigned years);
    longint unsigned y, d0;
    repeat (years) begin
      y  = $urandom_range(1971, 2513);
      d0 = first_day_of(y);
      send_seconds(with_junk((d0 - 1) * SEC_PER_DAY + SEC_PER_DAY - 1));
      send_seconds(with_junk(d0 * SEC_PER_DAY));
      send_seconds(with_junk((d0 + 58) * SEC_PER_DAY + $urandom_range(0, 86399)));
      send_seconds(with_junk((d0 + 59) * SEC_PER_DAY + $urandom_range(0, 86399)));
    end
  endtask

  task automatic test_drain_pause();
    send_seconds(with_junk({$urandom, $urandom}));
    in_tvalid <= 1'b0;
    wait_all_dates();
    send_seconds(with_junk({$urandom, $urandom}));
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned     phase_left;
    longint unsigned day_n, sod;
    phase_left = 0;
    repeat (count) begin
      if (phase_left == 0) begin
        idle_on    = ($urandom_range(0, 3) != 0);
        phase_left = $urandom_range(40, 200);
      end
      phase_left--;
      if ($urandom_range(0, 3) == 0) begin
        day_n = $urandom_range(0, 32'(MAX_DAY - 1));
        case ($urandom_range(0, 2))
          0:       sod = 0;
          1:       sod = SEC_PER_DAY - 1;
          default: sod = $urandom_range(0, 86399);
        endcase
        send_seconds(with_junk(day_n * SEC_PER_DAY + sod));
      end else begin
        send_seconds(IN_W'({$urandom, $urandom}));
      end
    end
  endtask

  task automatic test_full_rate(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_seconds(IN_W'({$urandom, $urandom}));
  endtask

  initial begin
    failed    = 1'b0;
    idle_on   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_year_edges(40);
    test_drain_pause();
    test_random(1064);
    test_full_rate(150);

    in_tvalid <= 1'b0;
    wait_all_dates();
    repeat (NUM_STAGES + 4) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
